// ===== rtl/core/rtspdf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtspdf_pkg: shared types and constants for the RTSP interleaved deframer
// Parse modes, result kinds, length width and the header name pattern.
// ----------------------------------------------------------------------------
package rtspdf_pkg;

	// Width of reported lengths and of the length counters
	localparam int LENGTH_BITS = 20;
	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

	// Length of "\r\nContent-Length:"
	localparam int NAME_LEN = 17;
	localparam int NAME_IDX_W = $clog2(NAME_LEN + 1);

	// Result kinds
	localparam logic [1:0] KIND_BINARY  = 2'd0;
	localparam logic [1:0] KIND_TEXT    = 2'd1;
	localparam logic [1:0] KIND_DISCARD = 2'd2;

	// Byte codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_LOW_L  = 8'h6c;

	// Position of the 'L' that may also be lower case
	localparam logic [NAME_IDX_W-1:0] NAME_CASE_POS = NAME_IDX_W'(10);

	typedef enum logic [2:0] {
		MODE_START  = 3'd0,
		MODE_BINARY = 3'd1,
		MODE_HEAD   = 3'd2,
		MODE_BODY   = 3'd3,
		MODE_HUNT   = 3'd4
	} mode_t;

	// Expected byte at each position of "\r\nContent-Length:"
	function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:    c = CH_CR;
			5'd1:    c = CH_LF;
			5'd2:    c = 8'h43; // C
			5'd3:    c = 8'h6f; // o
			5'd4:    c = 8'h6e; // n
			5'd5:    c = 8'h74; // t
			5'd6:    c = 8'h65; // e
			5'd7:    c = 8'h6e; // n
			5'd8:    c = 8'h74; // t
			5'd9:    c = 8'h2d; // -
			5'd10:   c = 8'h4c; // L
			5'd11:   c = 8'h65; // e
			5'd12:   c = 8'h6e; // n
			5'd13:   c = 8'h67; // g
			5'd14:   c = 8'h74; // t
			5'd15:   c = 8'h68; // h
			5'd16:   c = 8'h3a; // :
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/rtsp_interleaved_deframer_top.sv =====
// ----------------------------------------------------------------------------
// rtsp_interleaved_deframer_top: packet boundary finder for an RTSP stream
// Reports each interleaved binary packet, text message and discarded run.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and reports, on the byte that ends it, each
// '$' interleaved packet (kind 0, length 4 + payload), each RTSP text message
// (kind 1, header through CRLFCRLF plus Content-Length body) and each run of
// bytes thrown away while hunting for "$\0" or "RTSP" (kind 2). Lengths
// saturate at 2^20-1. A byte enters an input register and is parsed from it
// into the result register, so the block takes one byte every cycle; it
// stalls input only while a result waits on a stalled output. A discard run
// still open when the stream stops is never reported.
module rtsp_interleaved_deframer_top
	import rtspdf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [7:0]             data_byte,
	output logic                   packet_valid,
	input  logic                   packet_stall,
	output logic [1:0]             packet_kind,
	output logic [LENGTH_BITS-1:0] packet_length
);

	localparam int LW = LENGTH_BITS;

	// Saturating add of a small increment
	function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] a,
		input logic [2:0] inc);
		logic [LW:0] sum;
		sum = {1'b0, a} + (LW+1)'(inc);
		return sum[LW] ? LENGTH_MAX : sum[LW-1:0];
	endfunction

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register
	logic          res_valid_s2;
	logic [1:0]    res_kind_s2;
	logic [LW-1:0] res_len_s2;

	// Parser state
	mode_t                 mode_q, mode_d;
	logic [LW-1:0]         bc_q, bc_d;
	logic [15:0]           bl_q, bl_d;
	logic [1:0]            blm_q, blm_d;
	logic [NAME_IDX_W-1:0] hidx_q, hidx_d;
	logic [LW-1:0]         body_q, body_d;
	logic [1:0]            phase_q, phase_d;
	logic [2:0]            hm_q, hm_d;
	logic [LW-1:0]         disc_q, disc_d;

	logic          advance, accept;
	logic          emit, clr;
	logic [1:0]    emit_kind;
	logic [LW-1:0] emit_len;

	// Parse helpers
	logic          is_digit;
	logic [3:0]    digit_val;
	logic [LW+3:0] body_x10;
	logic          hunt_hit;
	logic [2:0]    hunt_base, hunt_add;
	logic [2:0]    hunt_hm;
	logic [7:0]    hunt_exp;
	logic          name_hit;
	logic          blank_hit;
	logic [LW-1:0] bc_inc;

	// Handshake
	assign advance    = valid_s1 && !(res_valid_s2 && packet_stall);
	assign byte_stall = valid_s1 && res_valid_s2 && packet_stall;
	assign accept     = byte_valid && !byte_stall;

	assign packet_valid  = res_valid_s2;
	assign packet_kind   = res_kind_s2;
	assign packet_length = res_len_s2;

	// Byte classes
	assign is_digit  = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit_val = 4'(byte_s1 - CH_ZERO);
	assign body_x10  = {1'b0, body_q, 3'b000} + {3'b000, body_q, 1'b0} + (LW+4)'(digit_val);
	assign bc_inc    = sat_add(bc_q, 3'd1);

	// Hunt matcher: start mode enters it with no progress
	always_comb begin
		hunt_hm = (mode_q == MODE_HUNT) ? hm_q : 3'd0;
		unique case (hunt_hm)
			3'd2:    hunt_exp = CH_T;
			3'd3:    hunt_exp = CH_S;
			3'd4:    hunt_exp = CH_P;
			default: hunt_exp = CH_NUL;
		endcase
		hunt_hit  = (hunt_hm != 3'd0) && (byte_s1 == hunt_exp);
		if (hunt_hm == 3'd1) begin
			hunt_base = 3'd1;
		end else if (hunt_hm >= 3'd2 && hunt_hm <= 3'd4) begin
			hunt_base = hunt_hm - 3'd1;
		end else begin
			hunt_base = 3'd0;
		end
		hunt_add = hunt_base + 3'((byte_s1 != CH_DOLLAR) && (byte_s1 != CH_R));
	end

	// Header matchers
	assign name_hit = (hidx_q < NAME_IDX_W'(NAME_LEN)) &&
		((byte_s1 == name_char(hidx_q)) ||
		 ((hidx_q == NAME_CASE_POS) && (byte_s1 == CH_LOW_L)));
	assign blank_hit = (byte_s1 == (blm_q[0] ? CH_LF : CH_CR));

	// Next state of the parser
	always_comb begin
		mode_d    = mode_q;
		bc_d      = bc_q;
		bl_d      = bl_q;
		blm_d     = blm_q;
		hidx_d    = hidx_q;
		body_d    = body_q;
		phase_d   = phase_q;
		hm_d      = hm_q;
		disc_d    = disc_q;
		emit      = 1'b0;
		emit_kind = KIND_DISCARD;
		emit_len  = disc_q;
		clr       = 1'b0;

		unique case (mode_q)
			MODE_START: begin
				if (bc_q == '0 && byte_s1 == CH_DOLLAR) begin
					mode_d = MODE_BINARY;
					bc_d   = LW'(1);
				end else if (byte_s1 == (bc_q[1] ? (bc_q[0] ? CH_P : CH_S)
						: (bc_q[0] ? CH_T : CH_R))) begin
					if (bc_q[1:0] == 2'd3) begin
						mode_d = MODE_HEAD;
						bc_d   = LW'(4);
					end else begin
						bc_d = bc_inc;
					end
				end else begin
					// fall into the hunt, keeping the partial match as discarded
					mode_d = MODE_HUNT;
					bc_d   = '0;
					disc_d = sat_add(LW'(bc_q[1:0]), hunt_add);
					if (byte_s1 == CH_DOLLAR) begin
						hm_d = 3'd1;
					end else if (byte_s1 == CH_R) begin
						hm_d = 3'd2;
					end else begin
						hm_d = 3'd0;
					end
				end
			end
			MODE_HUNT: begin
				if (hunt_hm == 3'd1 && byte_s1 == CH_NUL) begin
					emit   = 1'b1;
					clr    = 1'b1;
					mode_d = MODE_BINARY;
					bc_d   = LW'(2);
				end else if (hunt_hit && hunt_hm == 3'd4) begin
					emit   = 1'b1;
					clr    = 1'b1;
					mode_d = MODE_HEAD;
					bc_d   = LW'(4);
				end else if (hunt_hit) begin
					hm_d = hunt_hm + 3'd1;
				end else begin
					disc_d = sat_add(disc_q, hunt_add);
					if (byte_s1 == CH_DOLLAR) begin
						hm_d = 3'd1;
					end else if (byte_s1 == CH_R) begin
						hm_d = 3'd2;
					end else begin
						hm_d = 3'd0;
					end
				end
			end
			MODE_BINARY: begin
				emit_kind = KIND_BINARY;
				if (bc_q < LW'(4)) begin
					if (bc_q == LW'(2)) begin
						bl_d = {byte_s1, 8'h00};
					end else if (bc_q == LW'(3)) begin
						bl_d = {bl_q[15:8], byte_s1};
					end
					bc_d = bc_inc;
					if (bc_q == LW'(3) && bl_d == '0) begin
						emit     = 1'b1;
						emit_len = LW'(4);
						clr      = 1'b1;
						mode_d   = MODE_START;
						bc_d     = '0;
					end
				end else begin
					bc_d = bc_inc;
					if (bl_q != '0) begin
						bl_d = bl_q - 16'd1;
					end
					if (bl_d == '0) begin
						emit     = 1'b1;
						emit_len = bc_inc;
						clr      = 1'b1;
						mode_d   = MODE_START;
						bc_d     = '0;
					end
				end
			end
			MODE_HEAD: begin
				emit_kind = KIND_TEXT;
				bc_d      = bc_inc;
				// Content-Length name and value
				unique case (phase_q)
					2'd0: begin
						if (name_hit) begin
							hidx_d = hidx_q + NAME_IDX_W'(1);
							if (hidx_q == NAME_IDX_W'(NAME_LEN - 1)) begin
								phase_d = 2'd1;
								body_d  = '0;
							end
						end else begin
							hidx_d = NAME_IDX_W'(byte_s1 == CH_CR);
						end
					end
					2'd1: begin
						if (is_digit) begin
							body_d  = LW'(digit_val);
							phase_d = 2'd2;
						end else if (byte_s1 == CH_PLUS) begin
							phase_d = 2'd2;
						end else if (byte_s1 == CH_MINUS) begin
							body_d  = '0;
							phase_d = 2'd3;
						end else if (byte_s1 != CH_SPACE && byte_s1 != CH_TAB) begin
							phase_d = 2'd3;
						end
					end
					2'd2: begin
						if (is_digit) begin
							body_d = (body_x10[LW+3:LW] != '0) ? LENGTH_MAX
								: body_x10[LW-1:0];
						end else begin
							phase_d = 2'd3;
						end
					end
					default: begin
					end
				endcase
				// End of header
				if (blank_hit) begin
					if (blm_q == 2'd3) begin
						if (body_d == '0) begin
							emit     = 1'b1;
							emit_len = bc_inc;
							clr      = 1'b1;
							mode_d   = MODE_START;
							bc_d     = '0;
						end else begin
							blm_d  = 2'd0;
							mode_d = MODE_BODY;
						end
					end else begin
						blm_d = blm_q + 2'd1;
					end
				end else begin
					blm_d = 2'(byte_s1 == CH_CR);
				end
			end
			MODE_BODY: begin
				emit_kind = KIND_TEXT;
				bc_d      = bc_inc;
				if (body_q != '0) begin
					body_d = body_q - LW'(1);
				end
				if (body_d == '0) begin
					emit     = 1'b1;
					emit_len = bc_inc;
					clr      = 1'b1;
					mode_d   = MODE_START;
					bc_d     = '0;
				end
			end
			default: begin
				clr    = 1'b1;
				mode_d = MODE_START;
				bc_d   = '0;
			end
		endcase

		// Packet end or hunt exit clears the rest
		if (clr) begin
			bl_d    = '0;
			blm_d   = '0;
			hidx_d  = '0;
			body_d  = '0;
			phase_d = '0;
			hm_d    = '0;
			disc_d  = '0;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START;
			bc_q    <= '0;
			bl_q    <= '0;
			blm_q   <= '0;
			hidx_q  <= '0;
			body_q  <= '0;
			phase_q <= '0;
			hm_q    <= '0;
			disc_q  <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			bc_q    <= bc_d;
			bl_q    <= bl_d;
			blm_q   <= blm_d;
			hidx_q  <= hidx_d;
			body_q  <= body_d;
			phase_q <= phase_d;
			hm_q    <= hm_d;
			disc_q  <= disc_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= emit;
		end else if (!packet_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_kind_s2 <= emit_kind;
			res_len_s2  <= emit_len;
		end
	end

endmodule

// ===== rtl/core/rtspdf_checker.sv =====
// ----------------------------------------------------------------------------
// rtspdf_checker: port-level checks for the RTSP interleaved deframer
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module rtspdf_checker
	import rtspdf_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   byte_valid,
	input logic                   byte_stall,
	input logic [7:0]             data_byte,
	input logic                   packet_valid,
	input logic                   packet_stall,
	input logic [1:0]             packet_kind,
	input logic [LENGTH_BITS-1:0] packet_length
);

	// A stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		packet_valid && packet_stall |=> packet_valid && $stable(packet_kind)
			&& $stable(packet_length))
		else $error("stalled result changed");

	// Only three kinds exist
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		packet_valid |-> packet_kind != 2'd3)
		else $error("illegal packet kind");

	// Binary packets carry at least the four byte header
	a_binary_len: assert property (@(posedge clk) disable iff (!arst_n)
		packet_valid && packet_kind == KIND_BINARY |-> packet_length >= LENGTH_BITS'(4))
		else $error("short binary packet");

	// Text messages hold at least "RTSP" plus the blank line
	a_text_len: assert property (@(posedge clk) disable iff (!arst_n)
		packet_valid && packet_kind == KIND_TEXT |-> packet_length >= LENGTH_BITS'(8))
		else $error("short text message");

	// Input backpressure only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> packet_valid && packet_stall)
		else $error("input stalled without output backpressure");

endmodule

bind rtsp_interleaved_deframer_top rtspdf_checker u_rtspdf_checker (.*);

// ===== test/tb_rtsp_interleaved_deframer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtsp_interleaved_deframer_top: self-checking bench for the RTSP deframer
// Streams directed and random camera bytes (interleaved packets, text messages
// and junk) with random input gaps and output stalls. A byte-level predictor
// models the deframer, and every reported packet is checked in order.
// ----------------------------------------------------------------------------
module tb_rtsp_interleaved_deframer_top;
	import rtspdf_pkg::*;

	localparam int     RANDOM_BYTES = 1500;
	localparam int     QUIET_BYTES  = 250;
	localparam int     DRAIN_CYCLES = 20;
	localparam longint CYCLE_LIMIT  = 2000000;

	localparam logic [7:0] CH_L_UPPER = 8'h4c;

	typedef struct packed {
		logic [1:0]             kind;
		logic [LENGTH_BITS-1:0] len;
	} packet_t;

	typedef struct packed {
		logic [7:0]             dat;
		bit                     typed;
		logic [1:0]             kind;
		logic [LENGTH_BITS-1:0] len;
	} dir_row_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   byte_valid   = 1'b0;
	logic                   byte_stall;
	logic [7:0]             data_byte    = 8'h00;
	logic                   packet_valid;
	logic                   packet_stall = 1'b0;
	logic [1:0]             packet_kind;
	logic [LENGTH_BITS-1:0] packet_length;

	rtsp_interleaved_deframer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.packet_valid (packet_valid),
		.packet_stall (packet_stall),
		.packet_kind  (packet_kind),
		.packet_length(packet_length)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Bench state
	packet_t    pending_packets[$];
	packet_t    due;
	logic [7:0] msg_q[$];
	bit         failed  = 1'b0;
	bit         gaps_on = 1'b1;
	bit         quiet   = 1'b0;
	int         sent_total = 0;
	int         stall_left = 0;
	longint     cycles = 0;

	// Predictor state
	mode_t                  pm;
	logic [LENGTH_BITS-1:0] pkt_cnt;
	logic [15:0]            bin_left;
	logic [2:0]             blank_cnt;
	logic [NAME_IDX_W-1:0]  name_pos;
	logic [LENGTH_BITS-1:0] body_left;
	logic [1:0]             num_phase;
	logic [2:0]             sync_pos;
	logic [LENGTH_BITS-1:0] disc_cnt;

	logic [7:0] name_bytes [NAME_LEN] = '{CH_CR, CH_LF, "C", "o", "n", "t", "e", "n", "t",
		"-", "L", "e", "n", "g", "t", "h", ":"};
	logic [7:0] rtsp_word  [4] = '{CH_R, CH_T, CH_S, CH_P};
	logic [7:0] blank_word [4] = '{CH_CR, CH_LF, CH_CR, CH_LF};

	// Directed stream: short packets, both hunt exits, extreme byte values
	dir_row_t dir_rows [23] = '{
		'{CH_DOLLAR, 1'b0, '0, '0},
		'{8'h01,     1'b0, '0, '0},
		'{CH_NUL,    1'b0, '0, '0},
		'{CH_NUL,    1'b1, KIND_BINARY, 20'd4},
		'{CH_DOLLAR, 1'b0, '0, '0},
		'{8'hff,     1'b0, '0, '0},
		'{CH_NUL,    1'b0, '0, '0},
		'{8'h01,     1'b0, '0, '0},
		'{8'hab,     1'b1, KIND_BINARY, 20'd5},
		'{8'hff,     1'b0, '0, '0},
		'{CH_R,      1'b0, '0, '0},
		'{CH_T,      1'b0, '0, '0},
		'{CH_S,      1'b0, '0, '0},
		'{CH_P,      1'b1, KIND_DISCARD, 20'd1},
		'{CH_CR,     1'b0, '0, '0},
		'{CH_LF,     1'b0, '0, '0},
		'{CH_CR,     1'b0, '0, '0},
		'{CH_LF,     1'b1, KIND_TEXT, 20'd8},
		'{8'hff,     1'b0, '0, '0},
		'{CH_DOLLAR, 1'b0, '0, '0},
		'{CH_NUL,    1'b1, KIND_DISCARD, 20'd1},
		'{CH_NUL,    1'b0, '0, '0},
		'{CH_NUL,    1'b1, KIND_BINARY, 20'd4}
	};

	function automatic logic [LENGTH_BITS-1:0] sat_inc(input longint a, input longint b);
		longint s;
		s = a + b;
		return (s > longint'(LENGTH_MAX)) ? LENGTH_MAX : LENGTH_BITS'(s);
	endfunction

	function automatic void clear_state();
		pm        = MODE_START;
		pkt_cnt   = '0;
		bin_left  = '0;
		blank_cnt = '0;
		name_pos  = '0;
		body_left = '0;
		num_phase = '0;
		sync_pos  = '0;
		disc_cnt  = '0;
	endfunction

	// Byte that breaks a hunt match: may open a new match, else it is junk
	function automatic void hunt_restart(input logic [7:0] b);
		if (b == CH_DOLLAR) begin
			sync_pos = 3'd1;
		end else if (b == CH_R) begin
			sync_pos = 3'd2;
		end else begin
			sync_pos = 3'd0;
			disc_cnt = sat_inc(disc_cnt, 1);
		end
	endfunction

	// Hunt for "$\0" or "RTSP"; the matched bytes open the next packet
	function automatic void hunt_step(input logic [7:0] b, output bit got, output packet_t pkt);
		got = 1'b0;
		pkt = '0;
		if (sync_pos == 3'd1) begin
			if (b == CH_NUL) begin
				pkt = '{KIND_DISCARD, disc_cnt};
				got = 1'b1;
				clear_state();
				pm      = MODE_BINARY;
				pkt_cnt = 20'd2;
				return;
			end
			disc_cnt = sat_inc(disc_cnt, 1);
			hunt_restart(b);
			return;
		end
		if (sync_pos >= 3'd2 && sync_pos <= 3'd4) begin
			if (b == rtsp_word[sync_pos - 3'd1]) begin
				sync_pos++;
				if (sync_pos == 3'd5) begin
					pkt = '{KIND_DISCARD, disc_cnt};
					got = 1'b1;
					clear_state();
					pm      = MODE_HEAD;
					pkt_cnt = 20'd4;
				end
				return;
			end
			disc_cnt = sat_inc(disc_cnt, sync_pos - 3'd1);
		end
		hunt_restart(b);
	endfunction

	// Advance the deframer model by one byte; got marks a reported packet
	function automatic void deframe_byte(input logic [7:0] b, output bit got,
		output packet_t pkt);
		bit is_digit;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		got = 1'b0;
		pkt = '0;
		case (pm)
			MODE_START: begin
				if (pkt_cnt == 0 && b == CH_DOLLAR) begin
					pm      = MODE_BINARY;
					pkt_cnt = 20'd1;
				end else if (b == rtsp_word[pkt_cnt[1:0]]) begin
					pkt_cnt++;
					if (pkt_cnt >= 4) begin
						pm      = MODE_HEAD;
						pkt_cnt = 20'd4;
					end
				end else begin
					disc_cnt = LENGTH_BITS'(pkt_cnt[1:0]);
					pkt_cnt  = '0;
					sync_pos = '0;
					pm       = MODE_HUNT;
					hunt_step(b, got, pkt);
				end
			end
			MODE_BINARY: begin
				if (pkt_cnt < 4) begin
					if (pkt_cnt == 2)
						bin_left = {b, 8'h00};
					else if (pkt_cnt == 3)
						bin_left[7:0] = b;
					pkt_cnt++;
					if (pkt_cnt == 4 && bin_left == 0) begin
						clear_state();
						pkt = '{KIND_BINARY, 20'd4};
						got = 1'b1;
					end
				end else begin
					pkt_cnt = sat_inc(pkt_cnt, 1);
					if (bin_left > 0)
						bin_left--;
					if (bin_left == 0) begin
						pkt = '{KIND_BINARY, pkt_cnt};
						got = 1'b1;
						clear_state();
					end
				end
			end
			MODE_HEAD: begin
				pkt_cnt = sat_inc(pkt_cnt, 1);
				// Content-Length name match, then the number after it
				if (num_phase == 2'd0) begin
					if (name_pos < NAME_LEN && (b == name_bytes[name_pos] ||
						(name_pos == NAME_CASE_POS && b == CH_LOW_L))) begin
						name_pos++;
						if (name_pos == NAME_LEN) begin
							num_phase = 2'd1;
							body_left = '0;
						end
					end else begin
						name_pos = (b == CH_CR) ? NAME_IDX_W'(1) : '0;
					end
				end else if (num_phase == 2'd1) begin
					if (is_digit) begin
						body_left = LENGTH_BITS'(b - CH_ZERO);
						num_phase = 2'd2;
					end else if (b == CH_PLUS) begin
						num_phase = 2'd2;
					end else if (b == CH_MINUS) begin
						body_left = '0;
						num_phase = 2'd3;
					end else if (b != CH_SPACE && b != CH_TAB) begin
						num_phase = 2'd3;
					end
				end else if (num_phase == 2'd2) begin
					if (is_digit)
						body_left = sat_inc(longint'(body_left) * 10, longint'(b - CH_ZERO));
					else
						num_phase = 2'd3;
				end
				// End of header on CR LF CR LF
				if (b == blank_word[blank_cnt[1:0]]) begin
					blank_cnt++;
					if (blank_cnt >= 4) begin
						if (body_left == 0) begin
							pkt = '{KIND_TEXT, pkt_cnt};
							got = 1'b1;
							clear_state();
						end else begin
							blank_cnt = '0;
							pm        = MODE_BODY;
						end
					end
				end else begin
					blank_cnt = (b == CH_CR) ? 3'd1 : 3'd0;
				end
			end
			MODE_BODY: begin
				pkt_cnt = sat_inc(pkt_cnt, 1);
				if (body_left > 0)
					body_left--;
				if (body_left == 0) begin
					pkt = '{KIND_TEXT, pkt_cnt};
					got = 1'b1;
					clear_state();
				end
			end
			MODE_HUNT: begin
				hunt_step(b, got, pkt);
			end
			default: begin
				clear_state();
			end
		endcase
	endfunction

	// Drive one byte, wait for it to be taken, and log what it should report
	task automatic send_byte(input logic [7:0] b, input bit typed, input packet_t typed_pkt);
		bit      got;
		packet_t pkt;
		if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		do @(posedge clk); while (byte_stall);
		deframe_byte(b, got, pkt);
		if (typed)
			pending_packets.push_back(typed_pkt);
		else if (got)
			pending_packets.push_back(pkt);
		sent_total++;
		@(negedge clk);
	endtask

	task automatic send_msg();
		foreach (msg_q[i])
			send_byte(msg_q[i], 1'b0, '0);
		msg_q.delete();
	endtask

	// Stream builders
	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_q.push_back(s[i]);
	endtask

	task automatic add_crlf();
		msg_q.push_back(CH_CR);
		msg_q.push_back(CH_LF);
	endtask

	task automatic add_header_line();
		int n;
		n = $urandom_range(0, 8);
		add_crlf();
		add_str("CSeq: ");
		repeat (n) msg_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
	endtask

	// "\r\nContent-Length:" with either case of L, then blanks
	task automatic add_name(input bit lower_l);
		add_crlf();
		add_str("Content-");
		msg_q.push_back(lower_l ? CH_LOW_L : CH_L_UPPER);
		add_str("ength:");
		repeat ($urandom_range(0, 2)) msg_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	task automatic add_text_msg();
		int    style;
		int    value;
		string digits;
		style = $urandom_range(0, 11);
		value = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 400) : $urandom_range(0, 24);
		digits = $sformatf("%0d", value);
		if ($urandom_range(0, 1))
			add_str("RTSP/1.0 200 OK");
		else
			add_str("RTSP/1.0 454 Session Not Found");
		repeat ($urandom_range(0, 2)) add_header_line();
		case (style)
			0: value = 0;
			1, 2, 3, 4, 5: begin
				add_name($urandom_range(0, 1));
				add_str(digits);
			end
			6: begin
				add_name($urandom_range(0, 1));
				add_str("+");
				add_str(digits);
			end
			7: begin
				add_name($urandom_range(0, 1));
				add_str("00");
				add_str(digits);
				add_str("x;");
			end
			8: begin
				add_name($urandom_range(0, 1));
				add_str("-");
				add_str(digits);
				value = 0;
			end
			9: begin
				add_name($urandom_range(0, 1));
				add_str("abc");
				value = 0;
			end
			10: begin
				// near miss on the header name
				add_crlf();
				if ($urandom_range(0, 1))
					add_str("Content-Type:");
				else
					add_str("content-length:");
				add_str(digits);
				value = 0;
			end
			default: begin
				// only the first length header counts
				add_name($urandom_range(0, 1));
				add_str(digits);
				add_header_line();
				add_name($urandom_range(0, 1));
				add_str($sformatf("%0d", $urandom_range(1, 99)));
			end
		endcase
		repeat ($urandom_range(0, 2)) add_header_line();
		add_crlf();
		add_crlf();
		repeat (value) msg_q.push_back(8'($urandom()));
	endtask

	task automatic add_binary_pkt(input logic [15:0] len, input logic [7:0] chan);
		msg_q.push_back(CH_DOLLAR);
		msg_q.push_back(chan);
		msg_q.push_back(len[15:8]);
		msg_q.push_back(len[7:0]);
		repeat (len) msg_q.push_back(8'($urandom()));
	endtask

	// Junk and broken openings
	task automatic add_noise();
		logic [7:0] b;
		int         n;
		case ($urandom_range(0, 3))
			0: begin
				repeat ($urandom_range(1, 6)) begin
					b = 8'($urandom());
					msg_q.push_back((b == CH_DOLLAR) ? 8'hff : b);
				end
			end
			1: begin
				add_str($urandom_range(0, 1) ? "RT" : "RR");
				if ($urandom_range(0, 1))
					add_str("S");
				add_str("x");
			end
			2: begin
				// lone '$' while hunting
				msg_q.push_back(8'h7e);
				msg_q.push_back(CH_DOLLAR);
				msg_q.push_back(8'($urandom_range(1, 255)));
			end
			default: begin
				// broken "RTSP" opening, then a resync on "$\0"
				n = $urandom_range(0, 8);
				msg_q.push_back(CH_R);
				msg_q.push_back(CH_DOLLAR);
				msg_q.push_back(CH_NUL);
				msg_q.push_back(CH_NUL);
				msg_q.push_back(8'(n));
				repeat (n) msg_q.push_back(8'($urandom()));
			end
		endcase
	endtask

	// Output stalls in bursts, with stall-free stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			packet_stall <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left != 0) begin
			packet_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if (!quiet && (cycles % 300) >= 100 && $urandom_range(0, 7) == 0) begin
			packet_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 9);
		end else begin
			packet_stall <= 1'b0;
		end
	end

	// Compare each reported packet with the oldest one predicted
	always @(posedge clk) begin
		if (arst_n && packet_valid && !packet_stall) begin
			if (pending_packets.size() == 0) begin
				$error("unexpected packet: kind %0d length %0d", packet_kind, packet_length);
				failed = 1'b1;
			end else begin
				due = pending_packets.pop_front();
				if (packet_kind !== due.kind) begin
					$error("packet_kind: expected %0d, got %0d", due.kind, packet_kind);
					failed = 1'b1;
				end
				if (packet_length !== due.len) begin
					$error("packet_length: expected %0d, got %0d", due.len, packet_length);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		packet_t want;
		int      pick;
		clear_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			want.kind = dir_rows[i].kind;
			want.len  = dir_rows[i].len;
			send_byte(dir_rows[i].dat, dir_rows[i].typed, want);
		end

		// Random stream: mostly well-formed packets, some junk
		while (sent_total < RANDOM_BYTES) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			quiet   = (sent_total > RANDOM_BYTES - QUIET_BYTES);
			pick    = $urandom_range(0, 99);
			if (pick < 45)
				add_text_msg();
			else if (pick < 85)
				add_binary_pkt(($urandom_range(0, 9) == 0) ? 16'($urandom_range(33, 300))
					: 16'($urandom_range(0, 32)), $urandom_range(0, 1) ? CH_NUL : 8'($urandom()));
			else
				add_noise();
			send_msg();
		end

		// Interleaved packet with a nonzero high length byte, then a message
		// whose saturated body never ends
		quiet = 1'b1;
		add_binary_pkt(16'h0100, CH_NUL);
		add_str("RTSP");
		add_name(1'b0);
		add_str("99999999");
		add_crlf();
		add_crlf();
		repeat (5) msg_q.push_back(8'($urandom()));
		send_msg();
		byte_valid <= 1'b0;

		while (pending_packets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
